### src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table modules.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int HANDLE_W    = 56;
    localparam int STAMP_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int INDEX_FLD_W = 24;
    localparam int STAMP_LSB   = 24;
    localparam int CMP_W       = INDEX_FLD_W + 1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_LINK   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        command_t                    command;
        logic [HANDLE_W-1:0]         handle;
        logic signed [VALUE_W-1:0]   node_value;
        logic [HANDLE_W-1:0]         link_handle;
    } request_t;

    typedef struct packed {
        status_t                     status;
        logic [HANDLE_W-1:0]         issued_handle;
        logic signed [VALUE_W-1:0]   read_value;
        logic [HANDLE_W-1:0]         read_link;
    } response_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [HANDLE_W-1:0] link;
        logic [STAMP_W-1:0]  stamp;
        logic                live;
    } slot_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

endpackage

### src/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Table of nodes reached through stamped handles (generational slot map).
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on request at a rising edge where start is high and
//   busy is low. The slot memory and the free stack are read at that edge;
//   the following cycle (busy high) checks the handle, writes the slot back,
//   pushes or pops the free stack and registers the response. The response
//   is shown on response with done high for exactly one cycle, the cycle
//   after busy, and transfers at the edge that ends it; nothing holds it.
//   Each command is a registered read of the slot memory followed by its
//   write-back; a new command may be started in the same cycle that shows the
//   previous response.
//   Handles: stamp in bits 55..24, slot index in bits 23..0. Adds reuse the
//   most recently freed slot first, then fresh slots up to SLOTS; with none
//   left the status is table full.
//   Reset clears the fill count, the high-water count and the stamp counter;
//   the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module generational_handle_table #(
    parameter int SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ght_pkg::request_t   request,
    output logic                done,
    output ght_pkg::response_t  response
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    ght_pkg::request_t             req_reg;
    ght_pkg::response_t            resp_reg;
    ght_pkg::response_t            resp_next;
    logic                          done_reg;
    logic                          done_next;
    logic [CNT_W-1:0]              used_reg;
    logic [CNT_W-1:0]              used_next;
    logic [ght_pkg::STAMP_W-1:0]   stamp_reg;
    logic [ght_pkg::STAMP_W-1:0]   stamp_next;
    logic [ght_pkg::STAMP_W-1:0]   stamp_inc;

    ght_pkg::slot_entry_t          rd_entry;
    ght_pkg::slot_entry_t          wr_entry;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    ght_pkg::stack_op_t            stk_op;
    logic [IDX_W-1:0]              stk_top;
    logic [CNT_W-1:0]              free_count;

    logic                          accept;
    logic                          have_free;
    logic                          full;
    logic                          index_ok;
    logic                          handle_ok;
    logic [IDX_W-1:0]              add_slot;
    logic [IDX_W-1:0]              req_slot;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg == S_EXEC);
    assign req_slot  = req_reg.handle[IDX_W-1:0];
    assign have_free = (free_count != '0);
    assign full      = !have_free && (used_reg == CNT_W'(SLOTS));
    assign add_slot  = have_free ? stk_top : used_reg[IDX_W-1:0];
    assign stamp_inc = stamp_reg + ght_pkg::STAMP_W'(1);
    assign index_ok  = ght_pkg::CMP_W'(req_reg.handle[ght_pkg::INDEX_FLD_W-1:0])
                       < ght_pkg::CMP_W'(used_reg);
    assign handle_ok = index_ok && rd_entry.live
                       && (rd_entry.stamp == req_reg.handle[ght_pkg::HANDLE_W-1:
                                                            ght_pkg::STAMP_LSB]);

    ght_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .clk     (clk),
        .rd_addr (request.handle[IDX_W-1:0]),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    ght_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (stk_op),
        .push_index (req_slot),
        .top_index  (stk_top),
        .count      (free_count)
    );

    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        done_next  = 1'b0;
        used_next  = used_reg;
        stamp_next = stamp_reg;
        wr_en      = 1'b0;
        wr_addr    = req_slot;
        wr_entry   = rd_entry;
        stk_op     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                resp_next  = '0;
                if (req_reg.command == ght_pkg::CMD_ADD)
                begin
                    if (full)
                    begin
                        resp_next.status = ght_pkg::ST_FULL;
                    end
                    else
                    begin
                        stamp_next     = stamp_inc;
                        wr_en          = 1'b1;
                        wr_addr        = add_slot;
                        wr_entry.value = req_reg.node_value;
                        wr_entry.link  = req_reg.link_handle;
                        wr_entry.stamp = stamp_inc;
                        wr_entry.live  = 1'b1;
                        stk_op.pop     = have_free;
                        if (!have_free)
                        begin
                            used_next = used_reg + CNT_W'(1);
                        end
                        resp_next.issued_handle = {stamp_inc,
                                                   ght_pkg::INDEX_FLD_W'(add_slot)};
                    end
                end
                else if (!handle_ok)
                begin
                    resp_next.status = ght_pkg::ST_INVALID;
                end
                else
                begin
                    case (req_reg.command)
                        ght_pkg::CMD_READ:
                        begin
                            resp_next.read_value = rd_entry.value;
                            resp_next.read_link  = rd_entry.link;
                        end
                        ght_pkg::CMD_REMOVE:
                        begin
                            wr_en         = 1'b1;
                            wr_entry.live = 1'b0;
                            stk_op.push   = 1'b1;
                        end
                        ght_pkg::CMD_LINK:
                        begin
                            wr_en         = 1'b1;
                            wr_entry.link = req_reg.link_handle;
                        end
                        default:
                        begin
                            resp_next.status = ght_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            used_reg  <= '0;
            stamp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            used_reg  <= used_next;
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        resp_reg <= resp_next;
    end

    assign done     = done_reg;
    assign response = resp_reg;

endmodule

### src/ght_slot_mem.sv
// ----------------------------------------------------------------------------
// ght_slot_mem
// Slot memory: value, link, stamp and live flag per slot, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ght_slot_mem #(
    parameter int SLOTS = 1024
) (
    input  logic                        clk,
    input  logic [$clog2(SLOTS)-1:0]    rd_addr,
    output ght_pkg::slot_entry_t        rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(SLOTS)-1:0]    wr_addr,
    input  ght_pkg::slot_entry_t        wr_data
);

    ght_pkg::slot_entry_t mem [SLOTS];
    ght_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/ght_free_stack.sv
// ----------------------------------------------------------------------------
// ght_free_stack
// Stack of freed slot indexes with its fill count; the top entry is read
// every cycle so it is ready when an add pops it.
// ----------------------------------------------------------------------------
module ght_free_stack #(
    parameter int SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ght_pkg::stack_op_t            op,
    input  logic [$clog2(SLOTS)-1:0]      push_index,
    output logic [$clog2(SLOTS)-1:0]      top_index,
    output logic [$clog2(SLOTS+1)-1:0]    count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [IDX_W-1:0] mem [SLOTS];
    logic [IDX_W-1:0] top_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;

    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (op.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[count_reg[IDX_W-1:0]] <= push_index;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= mem[count_dec[IDX_W-1:0]];
    end

    assign top_index = top_reg;
    assign count     = count_reg;

endmodule

### src/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_port_checker
// Port-level checks on the command and response timing of the handle table.
// ----------------------------------------------------------------------------
module ght_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input ght_pkg::response_t  response
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer not followed by busy");

    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("busy not followed by a response");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response without a command in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.status == ght_pkg::ST_OK
                  || response.status == ght_pkg::ST_INVALID
                  || response.status == ght_pkg::ST_FULL))
        else $error("undefined status code");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.status != ght_pkg::ST_OK |->
            response.issued_handle == '0 && response.read_value == '0
            && response.read_link == '0)
        else $error("failed command returned data");

endmodule

bind generational_handle_table ght_port_checker u_ght_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);

### test/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// Watches the command and response channels of the generational handle
// table. It keeps its own image of the slots, the free stack, the high-water
// count and the stamp counter, works out the response to every command that
// transfers, and compares each response with the oldest one still pending.
// ----------------------------------------------------------------------------
module ght_checker
    import ght_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  request_t   request,
    input  logic       done,
    input  response_t  response,
    output int         failures,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VALUE_W-1:0]  slot_value [SLOTS];
    logic [HANDLE_W-1:0] slot_link  [SLOTS];
    logic [STAMP_W-1:0]  slot_stamp [SLOTS];
    logic                slot_live  [SLOTS];
    int                  freed_slots [SLOTS];
    int                  freed_depth;
    int                  high_water;
    logic [STAMP_W-1:0]  stamp_count;
    response_t           due_responses [$];
    int                  fail_count = 0;

    assign failures = fail_count;

    task automatic note_failure(input string msg);
        $display("%0t ght_checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic apply_command(input request_t req, output response_t rsp);
        logic [STAMP_W-1:0] tag;
        int                 slot;
        bit                 valid;
        rsp = '0;
        rsp.status = ST_OK;
        tag = req.handle[HANDLE_W-1:STAMP_LSB];
        slot = int'(req.handle[INDEX_FLD_W-1:0]);
        valid = 1'b0;
        if (req.command == CMD_ADD)
        begin
            if (freed_depth > 0)
            begin
                freed_depth--;
                slot = freed_slots[freed_depth];
                valid = 1'b1;
            end
            else if (high_water < SLOTS)
            begin
                slot = high_water;
                high_water++;
                valid = 1'b1;
            end
            if (valid)
            begin
                stamp_count = stamp_count + 1'b1;
                slot_value[slot] = req.node_value;
                slot_link[slot] = req.link_handle;
                slot_stamp[slot] = stamp_count;
                slot_live[slot] = 1'b1;
                rsp.issued_handle = {stamp_count, INDEX_FLD_W'(slot)};
            end
            else
            begin
                rsp.status = ST_FULL;
            end
        end
        else
        begin
            if (slot < high_water)
            begin
                valid = slot_live[slot] && (slot_stamp[slot] == tag);
            end
            if (!valid)
            begin
                rsp.status = ST_INVALID;
            end
            else
            begin
                case (req.command)
                    CMD_READ:
                    begin
                        rsp.read_value = slot_value[slot];
                        rsp.read_link = slot_link[slot];
                    end
                    CMD_REMOVE:
                    begin
                        slot_live[slot] = 1'b0;
                        if (freed_depth < SLOTS)
                        begin
                            freed_slots[freed_depth] = slot;
                            freed_depth++;
                        end
                    end
                    default:
                    begin
                        slot_link[slot] = req.link_handle;
                    end
                endcase
            end
        end
    endtask

    task automatic compare_response(input response_t got, input response_t want);
        if (got.status !== want.status)
            note_failure($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.issued_handle !== want.issued_handle)
            note_failure($sformatf("issued_handle got %h want %h",
                                   got.issued_handle, want.issued_handle));
        if (got.read_value !== want.read_value)
            note_failure($sformatf("read_value got %h want %h",
                                   got.read_value, want.read_value));
        if (got.read_link !== want.read_link)
            note_failure($sformatf("read_link got %h want %h",
                                   got.read_link, want.read_link));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        response_t rsp;
        if (!rst_n)
        begin
            freed_depth = 0;
            high_water = 0;
            stamp_count = '0;
            due_responses.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_responses.size() == 0)
                    note_failure("response with no command outstanding");
                else
                    compare_response(response, due_responses.pop_front());
            end
            if (start && !busy)
            begin
                apply_command(request, rsp);
                due_responses = {due_responses, rsp};
            end
            pending <= due_responses.size();
        end
    end

endmodule

### test/generational_handle_table_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_table_tb
// Drives commands into the generational handle table: a directed opening
// over empty, stale, out-of-range and reused handles, then random traffic
// built mostly from handles the block has issued. Responses are checked by
// ght_checker.
// ----------------------------------------------------------------------------
module generational_handle_table_tb;
    import ght_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    response_t   response;
    int          failures;
    int          pending;
    int          idle_pct;
    logic [HANDLE_W-1:0] issued_pool [$];

    generational_handle_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    ght_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response),
        .failures (failures),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done && response.status == ST_OK && response.issued_handle != '0)
        begin
            issued_pool = {issued_pool, response.issued_handle};
            if (issued_pool.size() > 64)
                void'(issued_pool.pop_front());
        end
    end

    function automatic logic [HANDLE_W-1:0] rand56();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[HANDLE_W-1:0];
    endfunction

    function automatic logic [HANDLE_W-1:0] handle_of(input int stamp, input int index);
        return {STAMP_W'(stamp), INDEX_FLD_W'(index)};
    endfunction

    function automatic request_t make_req(input command_t cmd, input logic [HANDLE_W-1:0] h,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [HANDLE_W-1:0] link);
        request_t req;
        req.command = cmd;
        req.handle = h;
        req.node_value = value;
        req.link_handle = link;
        return req;
    endfunction

    task automatic send_command(input request_t req);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic random_request(output request_t req);
        int                  pick;
        int                  way;
        int                  bit_at;
        logic [HANDLE_W-1:0] h;
        pick = $urandom_range(99);
        way = $urandom_range(99);
        if (issued_pool.size() > 0 && way < 80)
        begin
            h = issued_pool[$urandom_range(issued_pool.size() - 1)];
            if (way >= 70)
            begin
                bit_at = $urandom_range(HANDLE_W - 1);
                h[bit_at] = ~h[bit_at];
            end
        end
        else if (way < 90)
            h = rand56();
        else
            h = {$urandom(), INDEX_FLD_W'($urandom_range(1100))};
        if (pick < 40)
            req.command = CMD_ADD;
        else if (pick < 65)
            req.command = CMD_READ;
        else if (pick < 80)
            req.command = CMD_REMOVE;
        else
            req.command = CMD_LINK;
        req.handle = h;
        req.node_value = $urandom();
        if (issued_pool.size() > 0 && $urandom_range(3) == 0)
            req.link_handle = issued_pool[$urandom_range(issued_pool.size() - 1)];
        else
            req.link_handle = rand56();
    endtask

    task automatic run_random(input int count);
        request_t req;
        repeat (count)
        begin
            random_request(req);
            send_command(req);
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        idle_pct = 38;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_command(make_req(CMD_READ, handle_of(0, 0), '0, '0));
        send_command(make_req(CMD_REMOVE, '1, '0, '0));
        send_command(make_req(CMD_LINK, '0, '1, '1));
        send_command(make_req(CMD_ADD, '0, 32'h8000_0000, '1));
        send_command(make_req(CMD_ADD, '1, 32'h7fff_ffff, '0));
        send_command(make_req(CMD_ADD, '0, 32'hffff_ffff, 56'h55_5555_5555_5555));
        send_command(make_req(CMD_READ, handle_of(1, 0), '0, '0));
        send_command(make_req(CMD_READ, handle_of(2, 0), '0, '0));
        send_command(make_req(CMD_READ, handle_of(1, 3), '0, '0));
        send_command(make_req(CMD_READ, '1, '0, '0));
        send_command(make_req(CMD_LINK, handle_of(2, 1), '0, '1));
        send_command(make_req(CMD_READ, handle_of(2, 1), '0, '0));
        send_command(make_req(CMD_REMOVE, handle_of(1, 0), '0, '0));
        send_command(make_req(CMD_READ, handle_of(1, 0), '0, '0));
        send_command(make_req(CMD_REMOVE, handle_of(1, 0), '0, '0));
        send_command(make_req(CMD_LINK, handle_of(1, 0), '0, '1));
        send_command(make_req(CMD_ADD, '0, '0, '0));
        send_command(make_req(CMD_READ, handle_of(4, 0), '0, '0));
        send_command(make_req(CMD_REMOVE, handle_of(3, 2), '0, '0));
        send_command(make_req(CMD_REMOVE, handle_of(2, 1), '0, '0));
        send_command(make_req(CMD_ADD, '0, 32'd1, 56'haa_aaaa_aaaa_aaaa));
        send_command(make_req(CMD_ADD, '0, 32'd2, '0));
        send_command(make_req(CMD_READ, handle_of(3, 2), '0, '0));
        send_command(make_req(CMD_READ, handle_of(6, 2), '0, '0));

        run_random(160);
        idle_pct = 57;
        run_random(160);
        idle_pct = 0;
        run_random(160);

        @(negedge clk);
        start <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("generational_handle_table_tb: PASS");
        else
            $display("generational_handle_table_tb: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("generational_handle_table_tb: FAIL");
        $finish;
    end

endmodule

### files.f
src/ght_pkg.sv
src/ght_slot_mem.sv
src/ght_free_stack.sv
src/generational_handle_table.sv
src/ght_checker.sv
test/ght_checker.sv
test/generational_handle_table_tb.sv
